@@ design/period_string_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the period string parser
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PERIOD_STRING_PARSER_UNIT_ASSERT_SVH
`define PERIOD_STRING_PARSER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/psp_pkg.sv @@
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constants for the period string parser: widths, status codes,
// suffix codes and the arithmetic constants of the unit conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

  localparam int MAX_STRING_CHARS = 63;
  // Character counter saturates at MAX_STRING_CHARS + 1.
  localparam int CCNT_W = $clog2(MAX_STRING_CHARS + 2);

  localparam int ACC_W    = 34;
  localparam int VAL_W    = 31;
  localparam int MULK_W   = 30;
  localparam int DEN_W    = 35;
  localparam int DIV_W    = 37;
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int PERIOD_W = 61;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 64;

  localparam logic [STATUS_W-1:0] ST_PERIOD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHUT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  localparam logic [3:0] MAX_DIGITS = 4'd10;
  localparam logic [3:0] DIGIT_OVER = 4'd11;

  localparam logic [ACC_W-1:0] VALUE_LIMIT     = 34'd2147483647;
  localparam logic [ACC_W-1:0] TEN_DIGIT_FLOOR = 34'd1073741823;
  localparam logic [ACC_W-1:0] PCT_FULL        = 34'd100;

  localparam logic [7:0] CH_NUL = 8'h00;

  // Suffix bytes as they are shifted in, newest byte lowest.
  localparam logic [23:0] SFX_S   = {8'h00, 8'h00, 8'h73};
  localparam logic [23:0] SFX_MS  = {8'h00, 8'h6d, 8'h73};
  localparam logic [23:0] SFX_US  = {8'h00, 8'h75, 8'h73};
  localparam logic [23:0] SFX_NS  = {8'h00, 8'h6e, 8'h73};
  localparam logic [23:0] SFX_BPS = {8'h62, 8'h70, 8'h73};
  localparam logic [23:0] SFX_CPS = {8'h63, 8'h70, 8'h73};
  localparam logic [23:0] SFX_PCT = {8'h00, 8'h00, 8'h25};

  localparam logic [MULK_W-1:0] K_SEC  = 30'd1000000000;
  localparam logic [MULK_W-1:0] K_MSEC = 30'd1000000;
  localparam logic [MULK_W-1:0] K_USEC = 30'd1000;
  localparam logic [MULK_W-1:0] K_NSEC = 30'd1;

  localparam logic [DIV_W-1:0] BPS_NUM = 37'd80000000000;
  localparam logic [DIV_W-1:0] CPS_NUM = 37'd100000000000;

endpackage

`default_nettype wire

@@ design/period_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// period_string_parser_unit
// Parses a decimal period string with a unit suffix into nanoseconds.
// ----------------------------------------------------------------------------
// Usage:
// Characters arrive on the s_ channel, one per transfer, with s_tlast on the
// final one. Each non-final character is absorbed as it arrives. The final
// character starts the evaluation and s_tready stays low until the result
// has been handed to the output register.
// One result per string leaves on the m_ channel: status in m_tuser[1:0]
// and the period in nanoseconds in m_tdata[60:0].
// Invalid, shut and percent results go from S_CHECK straight to S_DONE;
// s, ms, us, ns and no suffix pass through S_MUL (one registered multiply),
// and bps and cps pass through S_PREP and S_DIV, a restoring divider
// that produces one quotient bit per cycle over 37 bits.
// s_tready comes back in the cycle m_tvalid rises, so the next string
// starts only once the result has reached the output register.
// The output register lets the next string stream in while a result waits;
// if the receiver stalls, a second result is held and s_tready stays low
// until the first is taken.
// A synchronous reset clears the parse state and drops m_tvalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module period_string_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] character
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [60:0] period_ns, [63:61] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [1:0] K_FIN = 2'd0;
  localparam logic [1:0] K_MUL = 2'd1;
  localparam logic [1:0] K_DIV = 2'd2;

  logic [2:0]                    state;
  logic [psp_pkg::ACC_W-1:0]     acc;
  logic [3:0]                    dcnt;
  logic [psp_pkg::CCNT_W-1:0]    ccnt;
  logic                          in_sfx;
  logic [23:0]                   sfx;
  logic [2:0]                    slen;
  logic                          bad;
  logic [psp_pkg::STEP_W-1:0]    step;

  logic [psp_pkg::MULK_W-1:0]    mul_k;
  logic [psp_pkg::DEN_W-1:0]     den;
  logic [psp_pkg::DIV_W-1:0]     num;
  logic [psp_pkg::DEN_W-1:0]     rem;
  logic [psp_pkg::STATUS_W-1:0]  res_status;
  logic [psp_pkg::PERIOD_W-1:0]  res_period;

  logic                          take;
  logic                          is_digit;
  logic [psp_pkg::ACC_W-1:0]     acc_next;
  logic                          out_free;

  logic [psp_pkg::VAL_W-1:0]     v31;
  logic [psp_pkg::DEN_W-1:0]     v10;
  logic                          invalid;
  logic [1:0]                    chk_kind;
  logic [psp_pkg::STATUS_W-1:0]  chk_status;
  logic [psp_pkg::MULK_W-1:0]    chk_k;
  logic [psp_pkg::DIV_W-1:0]     chk_num;
  logic [psp_pkg::PERIOD_W-1:0]  mul_prod;

  logic [psp_pkg::DEN_W:0]       rem_sh;
  logic                          ge;
  logic [psp_pkg::DEN_W:0]       rem_diff;
  logic [psp_pkg::DIV_W-1:0]     num_next;

  assign s_tready = (state == S_IDLE);
  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_digit = !in_sfx && (s_tdata inside {[8'h30:8'h39]});

  // acc * 10 + digit; only used while fewer than ten digits are in, so the
  // value stays below 10^10, which fits in the 34-bit accumulator.
  assign acc_next = {acc[psp_pkg::ACC_W-4:0], 3'b000} + {acc[psp_pkg::ACC_W-2:0], 1'b0}
                  + {30'd0, s_tdata[3:0]};

  assign v31 = acc[psp_pkg::VAL_W-1:0];
  assign v10 = {1'b0, v31, 3'b000} + {3'b000, v31, 1'b0};

  always_comb begin
    invalid = bad || (ccnt > psp_pkg::CCNT_W'(psp_pkg::MAX_STRING_CHARS))
           || (dcnt == 4'd0) || (dcnt > psp_pkg::MAX_DIGITS)
           || (acc > psp_pkg::VALUE_LIMIT)
           || ((dcnt == psp_pkg::MAX_DIGITS) && (acc < psp_pkg::TEN_DIGIT_FLOOR));
    chk_kind   = K_FIN;
    chk_status = psp_pkg::ST_INVALID;
    chk_k      = psp_pkg::K_NSEC;
    chk_num    = psp_pkg::BPS_NUM;
    if (!invalid) begin
      if ((slen == 3'd1) && (sfx == psp_pkg::SFX_S)) begin
        chk_kind   = K_MUL;
        chk_status = psp_pkg::ST_PERIOD;
        chk_k      = psp_pkg::K_SEC;
      end else if ((slen == 3'd0) || ((slen == 3'd2) && (sfx == psp_pkg::SFX_MS))) begin
        chk_kind   = K_MUL;
        chk_status = psp_pkg::ST_PERIOD;
        chk_k      = psp_pkg::K_MSEC;
      end else if ((slen == 3'd2) && (sfx == psp_pkg::SFX_US)) begin
        chk_kind   = K_MUL;
        chk_status = psp_pkg::ST_PERIOD;
        chk_k      = psp_pkg::K_USEC;
      end else if ((slen == 3'd2) && (sfx == psp_pkg::SFX_NS)) begin
        chk_kind   = K_MUL;
        chk_status = psp_pkg::ST_PERIOD;
      end else if ((slen == 3'd3)
                   && ((sfx == psp_pkg::SFX_BPS) || (sfx == psp_pkg::SFX_CPS))) begin
        if (acc == '0) begin
          chk_status = psp_pkg::ST_SHUT;
        end else begin
          chk_kind   = K_DIV;
          chk_status = psp_pkg::ST_PERIOD;
          chk_num    = (sfx == psp_pkg::SFX_CPS) ? psp_pkg::CPS_NUM : psp_pkg::BPS_NUM;
        end
      end else if ((slen == 3'd1) && (sfx == psp_pkg::SFX_PCT)) begin
        if (acc == '0) begin
          chk_status = psp_pkg::ST_SHUT;
        end else if (acc == psp_pkg::PCT_FULL) begin
          chk_status = psp_pkg::ST_PERIOD;
        end
      end
    end
  end

  assign mul_prod = v31 * mul_k;

  // One restoring division step. The rate conversion is computed as
  // (num + 5v) / (10v), which equals the rounded two-stage integer division.
  assign rem_sh   = {rem, num[psp_pkg::DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, den};
  assign ge       = !rem_diff[psp_pkg::DEN_W];
  assign num_next = {num[psp_pkg::DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      acc      <= '0;
      dcnt     <= '0;
      ccnt     <= '0;
      in_sfx   <= 1'b0;
      sfx      <= '0;
      slen     <= '0;
      bad      <= 1'b0;
      step     <= '0;
    end else begin
      // In S_DONE the valid flag is owned by the hand-over below.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            if (ccnt <= psp_pkg::CCNT_W'(psp_pkg::MAX_STRING_CHARS)) begin
              ccnt <= ccnt + 1'b1;
            end
            if (s_tdata == psp_pkg::CH_NUL) begin
              bad <= 1'b1;
            end
            if (is_digit) begin
              if (dcnt < psp_pkg::MAX_DIGITS) begin
                acc  <= acc_next;
                dcnt <= dcnt + 1'b1;
              end else begin
                dcnt <= psp_pkg::DIGIT_OVER;
              end
            end else begin
              in_sfx <= 1'b1;
              sfx    <= {sfx[15:0], s_tdata};
              if (slen < 3'd4) begin
                slen <= slen + 1'b1;
              end
            end
            if (s_tlast) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          step <= '0;
          case (chk_kind)
            K_MUL:   state <= S_MUL;
            K_DIV:   state <= S_PREP;
            default: state <= S_DONE;
          endcase
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == psp_pkg::STEP_W'(psp_pkg::DIV_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
            acc      <= '0;
            dcnt     <= '0;
            ccnt     <= '0;
            in_sfx   <= 1'b0;
            sfx      <= '0;
            slen     <= '0;
            bad      <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CHECK: begin
        mul_k      <= chk_k;
        den        <= v10;
        num        <= chk_num;
        rem        <= '0;
        res_status <= chk_status;
        res_period <= '0;
      end
      S_MUL: begin
        res_period <= mul_prod;
      end
      S_PREP: begin
        // Add 5v, which is half of the stored divisor 10v.
        num <= num + {3'b000, den[psp_pkg::DEN_W-1:1]};
      end
      S_DIV: begin
        num <= num_next;
        rem <= ge ? rem_diff[psp_pkg::DEN_W-1:0] : rem_sh[psp_pkg::DEN_W-1:0];
        if (step == psp_pkg::STEP_W'(psp_pkg::DIV_W - 1)) begin
          res_period <= {{(psp_pkg::PERIOD_W - psp_pkg::DIV_W){1'b0}}, num_next};
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_tdata <= {3'b000, res_period};
          m_tuser <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/psp_checker.sv @@
// ----------------------------------------------------------------------------
// psp_checker
// Port-level checks for the period string parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "period_string_parser_unit_assert.svh"

module psp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  `PSP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  `PSP_ASSERT_SAME(a_status_code, m_tvalid, (m_tuser == psp_pkg::ST_PERIOD) || (m_tuser == psp_pkg::ST_SHUT) || (m_tuser == psp_pkg::ST_INVALID), "unknown status code")

  `PSP_ASSERT_SAME(a_zero_period, m_tvalid && (m_tuser != psp_pkg::ST_PERIOD), m_tdata == '0, "period set on a shut or invalid result")

  `PSP_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input still ready after the final character")

  `PSP_ASSERT_SAME(a_result_source, $rose(m_tvalid), !$past(s_tready), "result appeared while parsing characters")

endmodule

bind period_string_parser_unit psp_checker u_psp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ dv/tb_period_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_period_string_parser_unit
// Self-checking testbench for the period string parser. Strings are streamed
// one character per transfer; a short table of directed strings is followed by
// random well-formed and broken strings. Every result is checked field by field
// against its table row or a behavioral predictor of parse and unit conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_period_string_parser_unit;

  localparam int          RANDOM_CHARS = 1750;
  localparam int          QUIET_CHARS  = 300;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          DRAIN_CYCLES = 60;
  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  CH_NINE      = 8'h39;

  typedef struct packed {
    logic [psp_pkg::STATUS_W-1:0] status;
    logic [psp_pkg::PERIOD_W-1:0] period_ns;
  } period_result_t;

  typedef struct {
    string                        txt;
    int                           nul_at;
    bit                           known;
    logic [psp_pkg::STATUS_W-1:0] status;
    longint unsigned              period_ns;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  // Expectation carried alongside the final character of a directed string.
  logic                         known_tag;
  logic [psp_pkg::STATUS_W-1:0] status_tag;
  logic [psp_pkg::PERIOD_W-1:0] period_tag;

  // Predictor state.
  logic [psp_pkg::ACC_W-1:0]  acc_val;
  logic [3:0]                 digits_seen;
  logic [psp_pkg::CCNT_W-1:0] chars_seen;
  bit                         past_digits;
  logic [23:0]                suffix_bytes;
  logic [2:0]                 suffix_len;
  bit                         saw_nul;

  period_result_t period_exp_q[$];
  logic [7:0]     str_buf[$];
  dir_row_t       dir_tab[$];
  int             error_count;
  int             chars_sent;
  bit             tx_idle;
  bit             rx_idle;
  int             hold_reqs;
  int             holds_done;

  period_string_parser_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    error_count++;
  endtask

  task automatic clear_parse();
    acc_val      = '0;
    digits_seen  = '0;
    chars_seen   = '0;
    past_digits  = 1'b0;
    suffix_bytes = '0;
    suffix_len   = '0;
    saw_nul      = 1'b0;
  endtask

  task automatic absorb_char(logic [7:0] c);
    if (chars_seen <= psp_pkg::MAX_STRING_CHARS) chars_seen++;
    if (c == psp_pkg::CH_NUL) saw_nul = 1'b1;
    if (!past_digits && c >= CH_ZERO && c <= CH_NINE) begin
      if (digits_seen < psp_pkg::MAX_DIGITS) begin
        acc_val = acc_val * 10 + psp_pkg::ACC_W'(c - CH_ZERO);
        digits_seen++;
      end else begin
        digits_seen = psp_pkg::DIGIT_OVER;
      end
    end else begin
      past_digits  = 1'b1;
      suffix_bytes = {suffix_bytes[15:0], c};
      if (suffix_len < 3'd4) suffix_len++;
    end
  endtask

  function automatic period_result_t predict_period();
    period_result_t  r;
    longint unsigned v;
    longint unsigned num;
    v = acc_val;
    r = '0;
    r.status = psp_pkg::ST_INVALID;
    if (saw_nul || chars_seen > psp_pkg::MAX_STRING_CHARS || digits_seen == 0 ||
        digits_seen > psp_pkg::MAX_DIGITS || acc_val > psp_pkg::VALUE_LIMIT ||
        (digits_seen == psp_pkg::MAX_DIGITS && acc_val < psp_pkg::TEN_DIGIT_FLOOR)) begin
      r.status = psp_pkg::ST_INVALID;
    end else if (suffix_len == 1 && suffix_bytes == psp_pkg::SFX_S) begin
      r.status = psp_pkg::ST_PERIOD;
      r.period_ns = psp_pkg::PERIOD_W'(v * psp_pkg::K_SEC);
    end else if (suffix_len == 0 ||
                 (suffix_len == 2 && suffix_bytes == psp_pkg::SFX_MS)) begin
      r.status = psp_pkg::ST_PERIOD;
      r.period_ns = psp_pkg::PERIOD_W'(v * psp_pkg::K_MSEC);
    end else if (suffix_len == 2 && suffix_bytes == psp_pkg::SFX_US) begin
      r.status = psp_pkg::ST_PERIOD;
      r.period_ns = psp_pkg::PERIOD_W'(v * psp_pkg::K_USEC);
    end else if (suffix_len == 2 && suffix_bytes == psp_pkg::SFX_NS) begin
      r.status = psp_pkg::ST_PERIOD;
      r.period_ns = psp_pkg::PERIOD_W'(v * psp_pkg::K_NSEC);
    end else if (suffix_len == 3 && (suffix_bytes == psp_pkg::SFX_BPS ||
                                     suffix_bytes == psp_pkg::SFX_CPS)) begin
      if (v == 0) begin
        r.status = psp_pkg::ST_SHUT;
      end else begin
        num = (suffix_bytes == psp_pkg::SFX_BPS) ? psp_pkg::BPS_NUM : psp_pkg::CPS_NUM;
        r.status = psp_pkg::ST_PERIOD;
        r.period_ns = psp_pkg::PERIOD_W'((num / v + 5) / 10);
      end
    end else if (suffix_len == 1 && suffix_bytes == psp_pkg::SFX_PCT) begin
      if (v == 0) r.status = psp_pkg::ST_SHUT;
      else if (acc_val == psp_pkg::PCT_FULL) r.status = psp_pkg::ST_PERIOD;
    end
    return r;
  endfunction

  // Input side: follow every accepted character and queue the result of a string.
  always @(posedge clk) begin
    period_result_t r;
    if (rst) begin
      clear_parse();
    end else if (s_tvalid && s_tready) begin
      absorb_char(s_tdata);
      if (s_tlast) begin
        r = predict_period();
        if (known_tag) begin
          r.status = status_tag;
          r.period_ns = period_tag;
        end
        period_exp_q.push_back(r);
        clear_parse();
      end
    end
  end

  // Output side: compare each result with the oldest expectation.
  always @(posedge clk) begin
    period_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (period_exp_q.size() == 0) begin
        report("result with nothing pending", m_tdata, 0);
      end else begin
        e = period_exp_q.pop_front();
        if (m_tuser != e.status) report("status", m_tuser, e.status);
        if (m_tdata[60:0] != e.period_ns) report("period_ns", m_tdata[60:0], e.period_ns);
        if (m_tdata[63:61] != 3'b000) report("spare bits", m_tdata[63:61], 0);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != hold_reqs) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Streams str_buf out, one character per transfer, tlast on the final one.
  task automatic send_buf(bit known, logic [psp_pkg::STATUS_W-1:0] st,
                          longint unsigned per);
    int i;
    for (i = 0; i < str_buf.size(); i++) begin
      if (tx_idle && $urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      s_tvalid   <= 1'b1;
      s_tdata    <= str_buf[i];
      s_tlast    <= (i == str_buf.size() - 1);
      known_tag  <= known;
      status_tag <= st;
      period_tag <= psp_pkg::PERIOD_W'(per);
      do @(posedge clk); while (!s_tready);
      chars_sent++;
    end
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  task automatic add_value();
    longint unsigned corner_vals[15] = '{0, 1, 9, 10, 99, 100, 101, 999999999,
                                         1073741822, 1073741823, 1073741824,
                                         64'd2147483647, 64'd2147483648,
                                         64'd4294967295, 64'd9999999999};
    longint unsigned v;
    string           s;
    int              w;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 999);
      1: begin
        repeat ($urandom_range(1, 10)) str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        return;
      end
      2: v = corner_vals[$urandom_range(0, 14)];
      3: v = 64'd1000000000 + ($urandom % 32'd1200000000);
      default: v = $urandom_range(0, 100);
    endcase
    s = $sformatf("%0d", v);
    // Leading zeros count as digits, which matters near ten digits.
    if ($urandom_range(0, 3) == 0 && s.len() < 10) begin
      w = $urandom_range(s.len(), 10);
      repeat (w - s.len()) str_buf.push_back(CH_ZERO);
    end
    push_text(s);
  endtask

  task automatic build_well_formed();
    string unit_names[8] = '{"", "s", "ms", "us", "ns", "bps", "cps", "%"};
    string pct_vals[4] = '{"0", "100", "00", "0100"};
    int    u;
    u = $urandom_range(0, 7);
    if (u == 7 && $urandom_range(0, 2) != 0) push_text(pct_vals[$urandom_range(0, 3)]);
    else add_value();
    push_text(unit_names[u]);
  endtask

  task automatic build_random();
    int kind;
    int n;
    str_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      build_well_formed();
    end else if (kind < 78) begin
      repeat ($urandom_range(1, 8)) str_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 84) begin
      build_well_formed();
      str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 90) begin
      build_well_formed();
      repeat ($urandom_range(1, 3)) str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (kind < 95) begin
      repeat ($urandom_range(11, 14)) str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      push_text("ns");
    end else begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(60, 68);
      repeat (n) str_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int str_idx;
    int dir_chars;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    known_tag  <= 1'b0;
    status_tag <= '0;
    period_tag <= '0;
    error_count = 0;
    chars_sent  = 0;
    hold_reqs   = 0;
    holds_done  = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;

    dir_tab.push_back('{"1s", -1, 1, psp_pkg::ST_PERIOD, 64'd1000000000});
    dir_tab.push_back('{"7", -1, 1, psp_pkg::ST_PERIOD, 64'd7000000});
    dir_tab.push_back('{"25ms", -1, 1, psp_pkg::ST_PERIOD, 64'd25000000});
    dir_tab.push_back('{"3us", -1, 1, psp_pkg::ST_PERIOD, 64'd3000});
    dir_tab.push_back('{"9ns", -1, 1, psp_pkg::ST_PERIOD, 64'd9});
    dir_tab.push_back('{"0s", -1, 1, psp_pkg::ST_PERIOD, 64'd0});
    dir_tab.push_back('{"2147483647s", -1, 1, psp_pkg::ST_PERIOD, 64'd2147483647000000000});
    dir_tab.push_back('{"2147483648ns", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"1073741822ns", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"1073741823ns", -1, 1, psp_pkg::ST_PERIOD, 64'd1073741823});
    dir_tab.push_back('{"0000000001ns", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"12345678901", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"0bps", -1, 1, psp_pkg::ST_SHUT, 0});
    dir_tab.push_back('{"1bps", -1, 1, psp_pkg::ST_PERIOD, 64'd8000000000});
    dir_tab.push_back('{"7bps", -1, 0, psp_pkg::ST_PERIOD, 0});
    dir_tab.push_back('{"3cps", -1, 0, psp_pkg::ST_PERIOD, 0});
    dir_tab.push_back('{"2147483647cps", -1, 0, psp_pkg::ST_PERIOD, 0});
    dir_tab.push_back('{"0%", -1, 1, psp_pkg::ST_SHUT, 0});
    dir_tab.push_back('{"100%", -1, 1, psp_pkg::ST_PERIOD, 0});
    dir_tab.push_back('{"50%", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"ms", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"5msx", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"1s2", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"5x", 1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"4\377", -1, 1, psp_pkg::ST_INVALID, 0});
    dir_tab.push_back('{"0123456789012345678901234567890123456789012345678901234567890123ms",
                        -1, 1, psp_pkg::ST_INVALID, 0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      str_buf.delete();
      push_text(dir_tab[r].txt);
      if (dir_tab[r].nul_at >= 0) str_buf[dir_tab[r].nul_at] = psp_pkg::CH_NUL;
      send_buf(dir_tab[r].known, dir_tab[r].status, dir_tab[r].period_ns);
    end
    dir_chars = chars_sent;

    str_idx = 0;
    while (chars_sent < dir_chars + RANDOM_CHARS) begin
      if (chars_sent > dir_chars + RANDOM_CHARS - QUIET_CHARS) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else if (holds_done == hold_reqs) begin
        if ($urandom_range(0, 9) == 0) tx_idle = !tx_idle;
        if ($urandom_range(0, 9) == 0) rx_idle = !rx_idle;
      end
      // Hold the receiver off while characters keep coming, so the output
      // register and the held result both fill and s_tready drops.
      if (str_idx == 30) begin
        hold_reqs++;
        tx_idle = 1'b0;
      end
      // Let the block drain completely before streaming on.
      if (str_idx == 80) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (period_exp_q.size() != 0);
      end
      build_random();
      send_buf(1'b0, psp_pkg::ST_PERIOD, 0);
      str_idx++;
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (period_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
